// ===== src/alu_pkg.sv =====
`default_nettype none
package alu_pkg;

	localparam int FLAG_Z = 3;
	localparam int FLAG_N = 2;
	localparam int FLAG_H = 1;
	localparam int FLAG_C = 0;

	localparam logic [7:0] DAA_LIMIT = 8'h99;
	localparam logic [7:0] DAA_HIGH = 8'h60;
	localparam logic [7:0] DAA_LOW = 8'h06;

	localparam logic [7:0] OP_RLCA = 8'h07;
	localparam logic [7:0] OP_RRCA = 8'h0F;
	localparam logic [7:0] OP_RLA = 8'h17;
	localparam logic [7:0] OP_RRA = 8'h1F;
	localparam logic [7:0] OP_DAA = 8'h27;
	localparam logic [7:0] OP_CPL = 8'h2F;
	localparam logic [7:0] OP_SCF = 8'h37;
	localparam logic [7:0] OP_CCF = 8'h3F;
	localparam logic [7:0] OP_ADDSP = 8'hE8;
	localparam logic [7:0] OP_LDHLSP = 8'hF8;

	// Operation classes decoded in the first stage.
	typedef enum logic [3:0] {
		K_PASS, K_ARITH, K_LOGIC, K_INC, K_DEC, K_ADDHL, K_ACCROT, K_DAA,
		K_CPL, K_SCF, K_CCF, K_ADDSP, K_CBSHIFT, K_BIT, K_RES, K_SET
	} kind_t;

	localparam logic [2:0] ALU_ADD = 3'd0;
	localparam logic [2:0] ALU_ADC = 3'd1;
	localparam logic [2:0] ALU_SUB = 3'd2;
	localparam logic [2:0] ALU_SBC = 3'd3;
	localparam logic [2:0] ALU_AND = 3'd4;
	localparam logic [2:0] ALU_XOR = 3'd5;
	localparam logic [2:0] ALU_OR = 3'd6;
	localparam logic [2:0] ALU_CP = 3'd7;

	typedef struct packed {
		logic [7:0] operation;
		logic prefixed;
		logic [7:0] operand_a;
		logic [7:0] operand_b;
		logic [15:0] wide_operand;
		logic [15:0] wide_addend;
		logic [3:0] flags_in;
	} alu_in_t;

	typedef struct packed {
		logic [7:0] byte_result;
		logic [15:0] wide_result;
		logic [3:0] flags_out;
		logic writes_back;
	} alu_out_t;

endpackage
`default_nettype wire

// ===== src/cpu_alu_and_flags_top.sv =====
// Execute unit of an 8-bit handheld CPU: ALU, rotates/shifts, bit ops, DAA
// and the sixteen-bit adds, with flag generation.
// Input channel: drive the operation beat on "din" and raise start; it is
// taken at a rising edge where start is high and busy is low. busy is never
// raised, so one beat can be taken every clock.
// Output channel: each result beat shows on "dout" for exactly one cycle,
// marked by done. Each accepted beat passes the stage 1, 2 and 3 registers
// before done is raised; throughput is one beat per clock.
// Stage 1 decodes the opcode, stage 2 does the adds and shifts, stage 3
// forms the flags and selects the result.
// The receiver cannot stall; results are never held.
// Reset (arst_n low) clears the valid bits, so no beat in flight survives.
`default_nettype none
module cpu_alu_and_flags_top
	import alu_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire alu_in_t din,
	output logic done,
	output alu_out_t dout
);

	// Stage 1: decode.
	logic v_s1;
	alu_in_t in_s1;
	kind_t kind_s1;

	kind_t kind_d;
	always_comb begin
		logic [7:0] op;
		op = din.operation;
		kind_d = K_PASS;
		if (din.prefixed) begin
			if (op[7:6] == 2'b00) kind_d = K_CBSHIFT;
			else if (op[7:6] == 2'b01) kind_d = K_BIT;
			else if (op[7:6] == 2'b10) kind_d = K_RES;
			else kind_d = K_SET;
		end else if (op[7:6] == 2'b10 || (op[7:6] == 2'b11 && op[2:0] == 3'd6)) begin
			if (op[5:3] == ALU_AND || op[5:3] == ALU_XOR || op[5:3] == ALU_OR)
				kind_d = K_LOGIC;
			else
				kind_d = K_ARITH;
		end else if (op[7:6] == 2'b00 && op[2:0] == 3'd4) kind_d = K_INC;
		else if (op[7:6] == 2'b00 && op[2:0] == 3'd5) kind_d = K_DEC;
		else if (op[7:6] == 2'b00 && op[3:0] == 4'h9) kind_d = K_ADDHL;
		else if (op == OP_RLCA || op == OP_RRCA || op == OP_RLA || op == OP_RRA)
			kind_d = K_ACCROT;
		else if (op == OP_DAA) kind_d = K_DAA;
		else if (op == OP_CPL) kind_d = K_CPL;
		else if (op == OP_SCF) kind_d = K_SCF;
		else if (op == OP_CCF) kind_d = K_CCF;
		else if (op == OP_ADDSP || op == OP_LDHLSP) kind_d = K_ADDSP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start;
	end
	always_ff @(posedge clk) begin
		in_s1 <= din;
		kind_s1 <= kind_d;
	end

	// Stage 2: adders and shifter.
	logic v_s2;
	alu_in_t in_s2;
	kind_t kind_s2;
	logic [8:0] sum_s2;
	logic [4:0] nib_s2;
	logic [16:0] wsum_s2;
	logic [12:0] w12_s2;
	logic [7:0] sh_s2;
	logic shc_s2;

	logic [8:0] sum_d;
	logic [4:0] nib_d;
	logic [16:0] wsum_d;
	logic [12:0] w12_d;
	logic [7:0] sh_d;
	logic shc_d;
	always_comb begin
		logic [7:0] a, b;
		logic cin, cy;
		logic [2:0] sel;
		a = in_s1.operand_a;
		b = in_s1.operand_b;
		cin = in_s1.flags_in[FLAG_C];
		sel = in_s1.operation[5:3];
		cy = (sel == ALU_ADC || sel == ALU_SBC) ? cin : 1'b0;
		sum_d = '0;
		nib_d = '0;
		if (kind_s1 == K_INC) begin
			sum_d = {1'b0, a} + 9'd1;
		end else if (kind_s1 == K_DEC) begin
			sum_d = {1'b0, a} - 9'd1;
		end else if (sel == ALU_ADD || sel == ALU_ADC) begin
			sum_d = {1'b0, a} + {1'b0, b} + {8'd0, cy};
			nib_d = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cy};
		end else begin
			// Borrow shows as bit 8 / bit 4 of the difference.
			sum_d = {1'b0, a} - {1'b0, b} - {8'd0, cy};
			nib_d = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cy};
		end
		if (kind_s1 == K_ADDSP) begin
			wsum_d = {1'b0, in_s1.wide_operand} + {1'b0, {8{b[7]}}, b};
			w12_d = {9'd0, in_s1.wide_operand[3:0]} + {9'd0, b[3:0]};
		end else begin
			wsum_d = {1'b0, in_s1.wide_operand} + {1'b0, in_s1.wide_addend};
			w12_d = {1'b0, in_s1.wide_operand[11:0]} + {1'b0, in_s1.wide_addend[11:0]};
		end
		case (in_s1.operation[5:3])
			3'd0: begin shc_d = a[7]; sh_d = {a[6:0], a[7]}; end
			3'd1: begin shc_d = a[0]; sh_d = {a[0], a[7:1]}; end
			3'd2: begin shc_d = a[7]; sh_d = {a[6:0], cin}; end
			3'd3: begin shc_d = a[0]; sh_d = {cin, a[7:1]}; end
			3'd4: begin shc_d = a[7]; sh_d = {a[6:0], 1'b0}; end
			3'd5: begin shc_d = a[0]; sh_d = {a[7], a[7:1]}; end
			3'd6: begin shc_d = 1'b0; sh_d = {a[3:0], a[7:4]}; end
			default: begin shc_d = a[0]; sh_d = {1'b0, a[7:1]}; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		in_s2 <= in_s1;
		kind_s2 <= kind_s1;
		sum_s2 <= sum_d;
		nib_s2 <= nib_d;
		wsum_s2 <= wsum_d;
		w12_s2 <= w12_d;
		sh_s2 <= sh_d;
		shc_s2 <= shc_d;
	end

	// Stage 3: result select and flags.
	logic v_s3;
	alu_out_t out_s3;
	alu_out_t out_d;
	always_comb begin
		logic [7:0] a, b, r, m, da;
		logic [3:0] f;
		logic [2:0] sel;
		logic dc;
		a = in_s2.operand_a;
		b = in_s2.operand_b;
		f = in_s2.flags_in;
		sel = in_s2.operation[5:3];
		m = 8'd1 << sel;
		out_d.byte_result = a;
		out_d.wide_result = in_s2.wide_operand;
		out_d.flags_out = f;
		out_d.writes_back = 1'b1;
		r = 8'd0;
		da = 8'd0;
		dc = 1'b0;
		case (kind_s2)
			K_ARITH: begin
				r = sum_s2[7:0];
				out_d.flags_out = {r == 8'd0, sel[1], nib_s2[4], sum_s2[8]};
				if (sel == ALU_CP) out_d.writes_back = 1'b0;
				else out_d.byte_result = r;
			end
			K_LOGIC: begin
				if (sel == ALU_AND) r = a & b;
				else if (sel == ALU_XOR) r = a ^ b;
				else r = a | b;
				out_d.byte_result = r;
				out_d.flags_out = {r == 8'd0, 1'b0, sel == ALU_AND, 1'b0};
			end
			K_INC: begin
				out_d.byte_result = sum_s2[7:0];
				out_d.flags_out = {sum_s2[7:0] == 8'd0, 1'b0, a[3:0] == 4'hF, f[FLAG_C]};
			end
			K_DEC: begin
				out_d.byte_result = sum_s2[7:0];
				out_d.flags_out = {sum_s2[7:0] == 8'd0, 1'b1, a[3:0] == 4'h0, f[FLAG_C]};
			end
			K_ADDHL: begin
				out_d.wide_result = wsum_s2[15:0];
				out_d.flags_out = {f[FLAG_Z], 1'b0, w12_s2[12], wsum_s2[16]};
			end
			K_ADDSP: begin
				out_d.wide_result = wsum_s2[15:0];
				out_d.flags_out = {2'b00, w12_s2[4],
					({1'b0, in_s2.wide_operand[7:0]} + {1'b0, b}) > 9'h0FF};
			end
			K_ACCROT: begin
				if (in_s2.operation == OP_RLCA) r = {a[6:0], a[7]};
				else if (in_s2.operation == OP_RRCA) r = {a[0], a[7:1]};
				else if (in_s2.operation == OP_RLA) r = {a[6:0], f[FLAG_C]};
				else r = {f[FLAG_C], a[7:1]};
				out_d.byte_result = r;
				out_d.flags_out = {3'b000, in_s2.operation[3] ? a[0] : a[7]};
			end
			K_DAA: begin
				da = a;
				dc = f[FLAG_C];
				if (!f[FLAG_N]) begin
					if (f[FLAG_C] || a > DAA_LIMIT) begin
						da = da + DAA_HIGH;
						dc = 1'b1;
					end
					if (f[FLAG_H] || a[3:0] > 4'd9) da = da + DAA_LOW;
				end else begin
					if (f[FLAG_C]) da = da - DAA_HIGH;
					if (f[FLAG_H]) da = da - DAA_LOW;
				end
				out_d.byte_result = da;
				out_d.flags_out = {da == 8'd0, f[FLAG_N], 1'b0, dc};
			end
			K_CPL: begin
				out_d.byte_result = ~a;
				out_d.flags_out = {f[FLAG_Z], 2'b11, f[FLAG_C]};
			end
			K_SCF: out_d.flags_out = {f[FLAG_Z], 3'b001};
			K_CCF: out_d.flags_out = {f[FLAG_Z], 2'b00, ~f[FLAG_C]};
			K_CBSHIFT: begin
				out_d.byte_result = sh_s2;
				out_d.flags_out = {sh_s2 == 8'd0, 2'b00, shc_s2};
			end
			K_BIT: begin
				out_d.writes_back = 1'b0;
				out_d.flags_out = {(a & m) == 8'd0, 2'b01, f[FLAG_C]};
			end
			K_RES: out_d.byte_result = a & ~m;
			K_SET: out_d.byte_result = a | m;
			default: out_d.writes_back = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		out_s3 <= out_d;
	end

	assign busy = 1'b0;
	assign done = v_s3;
	assign dout = out_s3;

endmodule
`default_nettype wire

// ===== src/alu_checker.sv =====
`default_nettype none
module alu_checker
	import alu_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire alu_in_t din,
	input wire logic done,
	input wire alu_out_t dout
);

	// Every accepted beat comes out, marked by done.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##3 done) else $error("result beat missing");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 3)) else $error("unexpected result beat");

	// Compare and BIT never write back; only register-form compare is checked here.
	a_cp_nowb: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !din.prefixed && din.operation[7:6] == 2'b10
			&& din.operation[5:3] == ALU_CP |-> ##3 !dout.writes_back)
		else $error("CP wrote back");

	a_busy_low: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

endmodule

bind cpu_alu_and_flags_top alu_checker u_alu_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.din(din), .done(done), .dout(dout)
);
`default_nettype wire
